### rtl/core/mcc_pkg.sv
// Package for the minimum chain cover core: sizes, key widths and shared types.
// Used by the channel interfaces, the compare unit and the top level.
package mcc_pkg;
    localparam int MAX_PAIRS = 4096;
    localparam int KEY_BITS  = 16;
    localparam int ADDR_W    = $clog2(MAX_PAIRS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int PAIR_W    = 2 * KEY_BITS;
    localparam int OUT_W     = 13;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [PAIR_W-1:0]   t_pair;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;
endpackage

### rtl/core/mcc_if.sv
// Valid/ready channel interfaces for pair input and result output.
// Depends on mcc_pkg for field types.
interface mcc_in_if;
    logic         valid;
    logic         ready;
    mcc_pkg::t_key pair_length;
    mcc_pkg::t_key pair_weight;
    logic         last_pair;
    modport source (output valid, pair_length, pair_weight, last_pair, input ready);
    modport sink   (input valid, pair_length, pair_weight, last_pair, output ready);
endinterface

interface mcc_out_if;
    logic                       valid;
    logic                       ready;
    logic [mcc_pkg::OUT_W-1:0]  chain_count;
    logic                       overflow;
    modport source (output valid, chain_count, overflow, input ready);
    modport sink   (input valid, chain_count, overflow, output ready);
endinterface

### rtl/core/min_chain_cover_of_pairs_core.sv
// Minimum chain cover core: sorted insertion of pairs, then a binary-searched tails scan.
// Each pair walks down the sorted store, shifting every larger entry up one slot
// (the first pair of a batch lands in an empty store without a compare).
// The last pair starts the tails scan, a binary search per stored pair, before the result.
// Both phases are bounded by the single compare unit and one RAM read port per store.
// Reset (sync, active low) clears count, top, ovf, out valid and state; RAM contents are kept.
module min_chain_cover_of_pairs_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcc_in_if.sink    i_in,
    mcc_out_if.source o_out
);
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_CMP = 7'b0000100,
        S_L_RD    = 7'b0001000,
        S_L_GET   = 7'b0010000,
        S_L_PROBE = 7'b0100000,
        S_L_CMP   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    mcc_pkg::t_cnt  r_count, n_count;
    mcc_pkg::t_addr r_top, n_top;
    logic           r_ovf, n_ovf;
    logic           r_last, n_last;
    mcc_pkg::t_pair r_new, n_new;
    mcc_pkg::t_cnt  r_pos, n_pos;
    mcc_pkg::t_cnt  r_i, n_i;
    mcc_pkg::t_key  r_w, n_w;
    mcc_pkg::t_cnt  r_lo, n_lo;
    mcc_pkg::t_cnt  r_hi, n_hi;
    logic           r_out_valid, n_out_valid;
    logic [mcc_pkg::OUT_W-1:0] r_out_count, n_out_count;
    logic           r_out_ovf, n_out_ovf;

    logic           p_we;
    mcc_pkg::t_addr p_waddr, p_raddr;
    mcc_pkg::t_pair p_wdata, p_rdata;
    logic           t_we;
    mcc_pkg::t_addr t_waddr, t_raddr;
    mcc_pkg::t_key  t_wdata, t_rdata;

    mcc_pkg::t_pair cmp_a, cmp_b;
    logic           cmp_gt;
    mcc_pkg::t_cnt  mid;
    mcc_pkg::t_cnt  top_ext;
    logic           in_fire;

    mcc_ram #(.WIDTH(mcc_pkg::PAIR_W), .DEPTH(mcc_pkg::MAX_PAIRS)) u_pair_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    mcc_ram #(.WIDTH(mcc_pkg::KEY_BITS), .DEPTH(mcc_pkg::MAX_PAIRS)) u_tails_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    mcc_cmp u_cmp (.i_a(cmp_a), .i_b(cmp_b), .o_gt(cmp_gt));

    assign i_in.ready        = (r_state == S_IDLE) && !r_out_valid;
    assign in_fire           = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.chain_count = r_out_count;
    assign o_out.overflow    = r_out_ovf;

    assign top_ext = {1'b0, r_top};
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);

    // The compare unit sees the sorted store during insertion and the tails otherwise.
    always_comb begin
        if (r_state == S_INS_CMP) begin
            cmp_a = p_rdata;
            cmp_b = r_new;
        end else begin
            cmp_a = {{mcc_pkg::KEY_BITS{1'b0}}, t_rdata};
            cmp_b = {{mcc_pkg::KEY_BITS{1'b0}}, r_w};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_new       = r_new;
        n_pos       = r_pos;
        n_i         = r_i;
        n_w         = r_w;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        p_we        = 1'b0;
        p_waddr     = r_pos[mcc_pkg::ADDR_W-1:0];
        p_wdata     = r_new;
        p_raddr     = r_i[mcc_pkg::ADDR_W-1:0];
        t_we        = 1'b0;
        t_waddr     = r_lo[mcc_pkg::ADDR_W-1:0];
        t_wdata     = r_w;
        t_raddr     = mid[mcc_pkg::ADDR_W-1:0];

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_last = i_in.last_pair;
                    n_i    = '0;
                    if (r_count == mcc_pkg::CNT_W'(mcc_pkg::MAX_PAIRS)) begin
                        n_ovf   = 1'b1;
                        n_state = i_in.last_pair ? S_L_RD : S_IDLE;
                    end else begin
                        n_new   = {i_in.pair_length, i_in.pair_weight};
                        n_pos   = r_count;
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    p_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = r_last ? S_L_RD : S_IDLE;
                end else begin
                    p_raddr = mcc_pkg::ADDR_W'(r_pos - 1'b1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                p_we = 1'b1;
                if (cmp_gt) begin
                    // Shift the larger entry up one slot and keep looking below.
                    p_wdata = p_rdata;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = r_last ? S_L_RD : S_IDLE;
                end
            end
            S_L_RD: begin
                if (r_i == r_count) begin
                    n_out_valid = 1'b1;
                    n_out_count = mcc_pkg::OUT_W'(top_ext + 1'b1);
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_top       = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_L_GET;
                end
            end
            S_L_GET: begin
                n_w = p_rdata[mcc_pkg::KEY_BITS-1:0];
                if (r_i == '0) begin
                    t_we    = 1'b1;
                    t_waddr = '0;
                    t_wdata = p_rdata[mcc_pkg::KEY_BITS-1:0];
                    n_top   = '0;
                    n_i     = r_i + 1'b1;
                    n_state = S_L_RD;
                end else begin
                    n_lo    = '0;
                    n_hi    = top_ext + 1'b1;
                    n_state = S_L_PROBE;
                end
            end
            S_L_PROBE: begin
                if (r_lo < r_hi) begin
                    n_state = S_L_CMP;
                end else begin
                    t_we = 1'b1;
                    if (r_lo > top_ext) begin
                        // Weight is below every tail: the table grows by one.
                        n_top   = r_top + 1'b1;
                        t_waddr = r_top + 1'b1;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_L_RD;
                end
            end
            S_L_CMP: begin
                if (!cmp_gt) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + 1'b1;
                end
                n_state = S_L_PROBE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_top       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_top       <= n_top;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_last      <= n_last;
        r_new       <= n_new;
        r_pos       <= n_pos;
        r_i         <= n_i;
        r_w         <= n_w;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end
endmodule

### rtl/core/mcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/mcc_cmp.sv
// Shared unsigned magnitude compare unit for insertion and tails search.
// Depends on mcc_pkg for the operand width.
module mcc_cmp (
    input  mcc_pkg::t_pair i_a,
    input  mcc_pkg::t_pair i_b,
    output logic           o_gt
);
    assign o_gt = (i_a > i_b);
endmodule
